// ===== sv/text_console_buffer_defines.svh =====
// Assertion macros shared by the console buffer modules.
// Each expects clk and rst_n in scope.
`ifndef TEXT_CONSOLE_BUFFER_DEFINES_SVH
`define TEXT_CONSOLE_BUFFER_DEFINES_SVH

// Condition holds at every edge out of reset.
`define TCB_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define TCB_CHECK_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCB_CHECK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tcb_pkg.sv =====
package tcb_pkg;

    // request codes
    localparam logic [2:0] REQ_PUT        = 3'd0;
    localparam logic [2:0] REQ_BACK       = 3'd1;
    localparam logic [2:0] REQ_CLEAR      = 3'd2;
    localparam logic [2:0] REQ_PAINT      = 3'd3;
    localparam logic [2:0] REQ_CLEAR_LINE = 3'd4;
    localparam logic [2:0] REQ_PAINT_LINE = 3'd5;
    localparam logic [2:0] REQ_READ       = 3'd6;

    localparam logic [7:0]  BLANK_CHAR   = 8'h20;
    localparam logic [7:0]  CLEAR_ATTR   = 8'h07;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [15:0] BLANK_CELL   = {CLEAR_ATTR, BLANK_CHAR};

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [4:0]  line_number;
        logic [10:0] cell_index;
    } req_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [15:0] cell_value;
        logic        ignored;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic idle;
        logic capture;
        logic exec;
        logic boot;
        logic fill_en;
        logic copy_en;
        logic bottom;
        logic read_cap;
        logic resp_load;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] req_type;
        logic       wrap;
        logic       line_ok;
        logic       idx_ok;
        logic       fill_last;
        logic       copy_last;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== sv/tcb_if.sv =====
interface tcb_req_if;
    logic          valid;
    logic          ready;
    tcb_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcb_rsp_if;
    logic          valid;
    logic          ready;
    tcb_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/tcb_ctrl.sv =====
`include "text_console_buffer_defines.svh"

module tcb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  tcb_pkg::dp_stat_t st,
    output tcb_pkg::ctl_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_BOOT  = 9'b000000001,
        S_CLEAR = 9'b000000010,
        S_IDLE  = 9'b000000100,
        S_EXEC  = 9'b000001000,
        S_COPY  = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_FILL  = 9'b001000000,
        S_READ  = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_BOOT:
            begin
                cmd.boot   = 1'b1;
                state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                cmd.fill_en = 1'b1;
                if (st.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.idle    = 1'b1;
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
                case (st.req_type)
                    tcb_pkg::REQ_PUT:
                    begin
                        if (st.wrap)
                        begin
                            state_next = S_COPY;
                        end
                    end
                    tcb_pkg::REQ_CLEAR, tcb_pkg::REQ_PAINT:
                    begin
                        state_next = S_FILL;
                    end
                    tcb_pkg::REQ_CLEAR_LINE, tcb_pkg::REQ_PAINT_LINE:
                    begin
                        if (st.line_ok)
                        begin
                            state_next = S_FILL;
                        end
                    end
                    tcb_pkg::REQ_READ:
                    begin
                        if (st.idx_ok)
                        begin
                            state_next = S_READ;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
                // commands with no store walk hand their word straight to the output when it is free
                if (state_next == S_RESP && st.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_COPY:
            begin
                cmd.copy_en = 1'b1;
                if (st.copy_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cmd.bottom = 1'b1;
                state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill_en = 1'b1;
                if (st.fill_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_READ:
            begin
                cmd.read_cap = 1'b1;
                state_next   = S_RESP;
                if (st.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_BOOT;
            end
        endcase
    end

    `TCB_CHECK_NXT(a_capture_exec, cmd.capture, state_reg == S_EXEC,
        "accepted word not executed next cycle")
    `TCB_CHECK_IMP(a_load_free, cmd.resp_load, st.out_free,
        "output register overwritten while full")
    `TCB_CHECK_IMP(a_ready_quiet, cmd.idle, !cmd.fill_en && !cmd.copy_en && !cmd.exec,
        "ready raised while store busy")

endmodule

// ===== sv/tcb_datapath.sv =====
`include "text_console_buffer_defines.svh"

module tcb_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tcb_pkg::ctl_cmd_t cmd,
    output tcb_pkg::dp_stat_t st,
    input  tcb_pkg::req_t     req_data,
    output logic              rsp_valid,
    output tcb_pkg::rsp_t     rsp_data,
    input  logic              rsp_ready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;

    tcb_pkg::req_t req_reg;

    logic [AW-1:0]  cur_reg, cur_next;
    logic [AW-1:0]  rs_reg, rs_next;
    logic [CLW-1:0] col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;

    logic [AW-1:0] fill_addr_reg, fill_addr_next;
    logic [AW-1:0] fill_last_reg, fill_last_next;
    logic [15:0]   fill_val_reg, fill_val_next;

    logic [AW-1:0] cp_reg, cp_next;
    logic          cpw_valid_reg;
    logic [AW-1:0] cpw_addr_reg;

    logic [15:0] res_value_reg, res_value_next;
    logic        res_ign_reg, res_ign_next;

    logic          out_valid_reg;
    tcb_pkg::rsp_t out_data_reg;

    logic          col_last, row_last, is_nl, wrap, line_ok, idx_ok, row_hit;
    logic [AW-1:0] line_start, cur_dec;
    logic [7:0]    fill_attr;

    logic          we;
    logic [AW-1:0] wa, ra;
    logic [15:0]   wd;

    assign col_last   = col_reg == CLW'(COLUMNS - 1);
    assign row_last   = row_reg == RW'(ROWS - 1);
    assign is_nl      = req_reg.char_code == tcb_pkg::NEWLINE_CHAR;
    assign wrap       = (req_reg.req_type == tcb_pkg::REQ_PUT) && row_last
                        && (is_nl || col_last);
    assign line_ok    = 32'(req_reg.line_number) < 32'(ROWS);
    assign idx_ok     = 32'(req_reg.cell_index) < 32'(CELLS);
    assign row_hit    = 32'(row_reg) == 32'(req_reg.line_number);
    assign line_start = AW'(32'(req_reg.line_number) * COLUMNS);
    assign cur_dec    = (cur_reg == '0) ? '0 : cur_reg - AW'(1);
    assign fill_attr  = (req_reg.req_type == tcb_pkg::REQ_PAINT ||
                         req_reg.req_type == tcb_pkg::REQ_PAINT_LINE)
                        ? req_reg.color : tcb_pkg::CLEAR_ATTR;

    assign st.req_type  = req_reg.req_type;
    assign st.wrap      = wrap;
    assign st.line_ok   = line_ok;
    assign st.idx_ok    = idx_ok;
    assign st.fill_last = fill_addr_reg == fill_last_reg;
    assign st.copy_last = cp_reg == AW'(CELLS - COLUMNS - 1);
    assign st.out_free  = !out_valid_reg || rsp_ready;

    // store port selection; a pending scroll copy always wins
    always_comb
    begin
        we = 1'b0;
        wa = cur_reg;
        wd = tcb_pkg::BLANK_CELL;
        if (cpw_valid_reg)
        begin
            we = 1'b1;
            wa = cpw_addr_reg;
            wd = rdata_reg;
        end
        else if (cmd.fill_en)
        begin
            we = 1'b1;
            wa = fill_addr_reg;
            wd = fill_val_reg;
        end
        else if (cmd.exec && req_reg.req_type == tcb_pkg::REQ_PUT && !is_nl)
        begin
            we = 1'b1;
            wa = cur_reg;
            wd = {req_reg.color, req_reg.char_code};
        end
        else if (cmd.exec && req_reg.req_type == tcb_pkg::REQ_BACK)
        begin
            we = 1'b1;
            wa = cur_dec;
            wd = tcb_pkg::BLANK_CELL;
        end
    end

    assign ra = cmd.copy_en ? cp_reg + AW'(COLUMNS) : AW'(req_reg.cell_index);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[ra];
    end

    always_comb
    begin
        cur_next       = cur_reg;
        rs_next        = rs_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        fill_addr_next = fill_addr_reg;
        fill_last_next = fill_last_reg;
        fill_val_next  = fill_val_reg;
        cp_next        = cp_reg;
        res_value_next = res_value_reg;
        res_ign_next   = res_ign_reg;

        if (cmd.boot || cmd.bottom)
        begin
            fill_addr_next = cmd.boot ? '0 : AW'(CELLS - COLUMNS);
            fill_last_next = AW'(CELLS - 1);
            fill_val_next  = tcb_pkg::BLANK_CELL;
        end
        if (cmd.fill_en)
        begin
            fill_addr_next = fill_addr_reg + AW'(1);
        end
        if (cmd.copy_en)
        begin
            cp_next = cp_reg + AW'(1);
        end
        if (cmd.read_cap)
        begin
            res_value_next = rdata_reg;
        end

        if (cmd.exec)
        begin
            res_value_next = '0;
            res_ign_next   = 1'b0;
            case (req_reg.req_type)
                tcb_pkg::REQ_PUT:
                begin
                    if (wrap)
                    begin
                        // scroll: cursor parks at the start of the bottom row
                        cur_next = AW'(CELLS - COLUMNS);
                        rs_next  = AW'(CELLS - COLUMNS);
                        row_next = RW'(ROWS - 1);
                        col_next = '0;
                        cp_next  = '0;
                    end
                    else if (is_nl || col_last)
                    begin
                        cur_next = rs_reg + AW'(COLUMNS);
                        rs_next  = rs_reg + AW'(COLUMNS);
                        row_next = row_reg + RW'(1);
                        col_next = '0;
                    end
                    else
                    begin
                        cur_next = cur_reg + AW'(1);
                        col_next = col_reg + CLW'(1);
                    end
                end
                tcb_pkg::REQ_BACK:
                begin
                    if (cur_reg != '0)
                    begin
                        cur_next = cur_dec;
                        if (col_reg == '0)
                        begin
                            col_next = CLW'(COLUMNS - 1);
                            row_next = row_reg - RW'(1);
                            rs_next  = rs_reg - AW'(COLUMNS);
                        end
                        else
                        begin
                            col_next = col_reg - CLW'(1);
                        end
                    end
                end
                tcb_pkg::REQ_CLEAR, tcb_pkg::REQ_PAINT:
                begin
                    cur_next       = '0;
                    rs_next        = '0;
                    col_next       = '0;
                    row_next       = '0;
                    fill_addr_next = '0;
                    fill_last_next = AW'(CELLS - 1);
                    fill_val_next  = {fill_attr, tcb_pkg::BLANK_CHAR};
                end
                tcb_pkg::REQ_CLEAR_LINE, tcb_pkg::REQ_PAINT_LINE:
                begin
                    if (line_ok)
                    begin
                        fill_addr_next = line_start;
                        fill_last_next = line_start + AW'(COLUMNS - 1);
                        fill_val_next  = {fill_attr, tcb_pkg::BLANK_CHAR};
                        if (row_hit)
                        begin
                            cur_next = rs_reg;
                            col_next = '0;
                        end
                    end
                    else
                    begin
                        res_ign_next = 1'b1;
                    end
                end
                tcb_pkg::REQ_READ:
                begin
                    res_ign_next = !idx_ok;
                end
                default:
                begin
                    res_ign_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_data;
        end
        fill_addr_reg <= fill_addr_next;
        fill_last_reg <= fill_last_next;
        fill_val_reg  <= fill_val_next;
        cpw_addr_reg  <= cp_reg;
        res_value_reg <= res_value_next;
        res_ign_reg   <= res_ign_next;
        if (cmd.resp_load)
        begin
            out_data_reg.cursor_pos <= 11'(cur_next);
            out_data_reg.cell_value <= res_value_next;
            out_data_reg.ignored    <= res_ign_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            rs_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cp_reg        <= '0;
            cpw_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            rs_reg        <= rs_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cp_reg        <= cp_next;
            cpw_valid_reg <= cmd.copy_en;
            if (cmd.resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    `TCB_CHECK(a_cur_split, cur_reg == rs_reg + AW'(col_reg),
        "cursor out of step with row start and column")
    `TCB_CHECK(a_cur_range, 32'(cur_reg) < 32'(CELLS), "cursor past last cell")
    `TCB_CHECK_IMP(a_copy_port, cpw_valid_reg, !cmd.fill_en && !cmd.exec,
        "store write port contended during scroll")

endmodule

// ===== sv/text_console_buffer.sv =====
// Text console buffer: a COLUMNS x ROWS grid of 16-bit cells (attribute in
// the high byte, character in the low byte) with a linear cursor.
// req channel (sink): one command word per handshake - put char, backspace,
//   clear/paint screen, clear/paint line, read cell. Taken when valid and
//   ready are both high; ready is high only while the engine is idle.
// rsp channel (source): exactly one word per command, carrying the cursor
//   after the command, the cell read (else zero) and the ignored flag.
// Path from acceptance to the output register, by command:
//   put char, backspace, rejected line/read, unused code: exec state only;
//   commands are taken one at a time, ready returning once a result loads.
//   read cell: exec, then the read state (registered store read).
//   clear/paint screen: exec, fill of COLUMNS*ROWS cells; line: COLUMNS cells.
//   put char that passes the last cell, or newline on the bottom row, scrolls:
//   copy, drain, fill, one cell per cycle through the single write port.
// Reset: the cursor goes to zero and the store is swept to blank (attr 07)
//   one cell a cycle, with ready held low.
// Stall: the result word waits in the output register; the next command is
//   still taken, but its result waits until the register is free.
module text_console_buffer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       clk,
    input  logic       rst_n,
    tcb_req_if.sink    req,
    tcb_rsp_if.source  rsp
);

    tcb_pkg::ctl_cmd_t cmd;
    tcb_pkg::dp_stat_t st;

    // controller sequences the store walks; ready is its idle state
    tcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .st        (st),
        .cmd       (cmd)
    );

    assign req.ready = cmd.idle;

    // cell store, cursor tracking and the output register
    tcb_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .req_data  (req.data),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data),
        .rsp_ready (rsp.ready)
    );

endmodule
